/* rtl/spt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpent package
// Shared constants, S-box functions and command types for the Serpent core.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int ROUND_COUNT = 32;
	localparam int KEY_WORDS   = 4 * (ROUND_COUNT + 1);
	localparam int KADDR_W     = $clog2(KEY_WORDS);
	localparam int RND_W       = $clog2(ROUND_COUNT + 1);
	localparam logic [31:0] GOLDEN = 32'h9e3779b9;

	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KEY3   = 3'd3;
	localparam logic [2:0] REG_KEYLEN = 3'd4;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	// Controller to datapath commands.
	typedef struct packed {
		logic             load;     // capture input block
		logic             round;    // apply one round step
		logic             decrypt;  // direction
		logic [RND_W-1:0] rnd;      // round number in use
	} spt_cmd_t;

	function automatic logic [3:0] sbox(input logic [2:0] b, input logic [3:0] x);
		logic [63:0] row;
		unique case (b)
			3'd0: row = {4'd12,4'd9,4'd0,4'd7,4'd2,4'd4,4'd13,4'd14,
				4'd11,4'd5,4'd6,4'd10,4'd1,4'd15,4'd8,4'd3};
			3'd1: row = {4'd4,4'd3,4'd13,4'd6,4'd8,4'd14,4'd11,4'd1,
				4'd10,4'd5,4'd0,4'd9,4'd7,4'd2,4'd12,4'd15};
			3'd2: row = {4'd2,4'd5,4'd11,4'd0,4'd4,4'd14,4'd1,4'd13,
				4'd15,4'd10,4'd12,4'd3,4'd9,4'd7,4'd6,4'd8};
			3'd3: row = {4'd14,4'd5,4'd7,4'd10,4'd4,4'd2,4'd1,4'd13,
				4'd3,4'd6,4'd9,4'd12,4'd8,4'd11,4'd15,4'd0};
			3'd4: row = {4'd13,4'd7,4'd14,4'd9,4'd10,4'd4,4'd5,4'd2,
				4'd6,4'd11,4'd0,4'd12,4'd3,4'd8,4'd15,4'd1};
			3'd5: row = {4'd1,4'd7,4'd6,4'd13,4'd8,4'd14,4'd3,4'd0,
				4'd12,4'd9,4'd10,4'd4,4'd11,4'd2,4'd5,4'd15};
			3'd6: row = {4'd0,4'd10,4'd3,4'd13,4'd15,4'd1,4'd9,4'd14,
				4'd11,4'd6,4'd4,4'd8,4'd5,4'd12,4'd2,4'd7};
			default: row = {4'd6,4'd5,4'd3,4'd9,4'd10,4'd12,4'd4,4'd7,
				4'd11,4'd2,4'd8,4'd14,4'd0,4'd15,4'd13,4'd1};
		endcase
		return row[x*4 +: 4];
	endfunction

	function automatic logic [3:0] sbox_inv(input logic [2:0] b, input logic [3:0] y);
		logic [3:0] r;
		r = 4'd0;
		for (int v = 0; v < 16; v++) begin
			if (sbox(b, 4'(v)) == y) begin
				r = 4'(v);
			end
		end
		return r;
	endfunction

	// Bitslice S-box over four words.
	function automatic logic [127:0] sbox_slice(input logic [2:0] b, input logic inv,
			input logic [127:0] x);
		logic [127:0] r;
		logic [3:0]   n;
		logic [3:0]   m;
		r = '0;
		for (int j = 0; j < 32; j++) begin
			n = {x[96+j], x[64+j], x[32+j], x[j]};
			m = inv ? sbox_inv(b, n) : sbox(b, n);
			r[j] = m[0];
			r[32+j] = m[1];
			r[64+j] = m[2];
			r[96+j] = m[3];
		end
		return r;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] lin_fwd(input logic [127:0] w);
		logic [31:0] x0, x1, x2, x3;
		x0 = w[31:0]; x1 = w[63:32]; x2 = w[95:64]; x3 = w[127:96];
		x0 = rotl(x0, 13);
		x2 = rotl(x2, 3);
		x1 = x1 ^ x0 ^ x2;
		x3 = x3 ^ x2 ^ (x0 << 3);
		x1 = rotl(x1, 1);
		x3 = rotl(x3, 7);
		x0 = x0 ^ x1 ^ x3;
		x2 = x2 ^ x3 ^ (x1 << 7);
		x0 = rotl(x0, 5);
		x2 = rotl(x2, 22);
		return {x3, x2, x1, x0};
	endfunction

	function automatic logic [127:0] lin_inv(input logic [127:0] w);
		logic [31:0] x0, x1, x2, x3;
		x0 = w[31:0]; x1 = w[63:32]; x2 = w[95:64]; x3 = w[127:96];
		x2 = rotl(x2, 10);
		x0 = rotl(x0, 27);
		x2 = x2 ^ x3 ^ (x1 << 7);
		x0 = x0 ^ x1 ^ x3;
		x3 = rotl(x3, 25);
		x1 = rotl(x1, 31);
		x3 = x3 ^ x2 ^ (x0 << 3);
		x1 = x1 ^ x0 ^ x2;
		x2 = rotl(x2, 29);
		x0 = rotl(x0, 19);
		return {x3, x2, x1, x0};
	endfunction

endpackage

/* rtl/serpent_block_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpent block cipher
// 128-bit Serpent encrypt/decrypt core with a configurable key of 0..32 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Key registers are written on the cfg channel (index 0..3: key bytes,
//   index 4: key length). Each write restarts subkey expansion; no block
//   word is accepted until it ends.
//   A block word on s_axis carries the command in tuser and the block in
//   tdata; the result word leaves on m_axis.
//   Each round has a fetch step, four reads of the subkey RAM through its
//   single registered read port, assembly of the 128-bit subkey, and the
//   round step. From acceptance to a valid result, a block goes through a
//   fetch of the final subkey, 32 rounds, and a load into the output
//   register. One block is in flight at a time; a new block is accepted
//   only after the last result has been loaded into the output register.
//   A finished result waits in the output register, and the next block is
//   accepted while it waits to be taken.
//   Reset loads the all-zero 32-byte key and expands it before the first
//   block is accepted.
// ----------------------------------------------------------------------------
module serpent_block_cipher
	import spt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // block_in_low, block_in_high
	input  logic         s_axis_tuser,   // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // block_out_low, block_out_high
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	spt_cmd_t         cmd;
	logic             ks_busy;
	logic             key_done;
	logic [127:0]     subkey;
	logic [127:0]     last_key_q;
	logic [127:0]     state;
	logic             fetch;
	logic [RND_W-1:0] fetch_grp;
	logic             out_load;
	logic             last_cap;
	logic             out_free;

	assign cfg_ready = 1'b1;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	spt_keysched u_ks (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fetch     (fetch),
		.fetch_grp (fetch_grp),
		.busy      (ks_busy),
		.key_done  (key_done),
		.subkey    (subkey)
	);

	spt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.ks_busy   (ks_busy),
		.key_done  (key_done),
		.out_free  (out_free),
		.out_load  (out_load),
		.last_cap  (last_cap),
		.cmd       (cmd),
		.fetch     (fetch),
		.fetch_grp (fetch_grp)
	);

	spt_datapath u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.block_in (s_axis_tdata),
		.subkey   (subkey),
		.last_key (last_key_q),
		.state    (state)
	);

	// Final subkey holding register.
	always_ff @(posedge clk) begin
		if (last_cap) begin
			last_key_q <= subkey;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= state;
		end
	end

endmodule

/* rtl/spt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module spt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 132
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/spt_keysched.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpent key schedule
// Holds the key registers and expands them into the subkey RAM, four words
// per step, then serves 128-bit subkeys to the round datapath.
// ----------------------------------------------------------------------------
module spt_keysched
	import spt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic                fetch,     // start reading subkey group
	input  logic [RND_W-1:0]    fetch_grp,
	output logic                busy,      // expansion in progress
	output logic                key_done,  // subkey group valid
	output logic [127:0]        subkey
);

	logic [255:0]        key_q;
	logic [5:0]          len_q;
	logic                exp_q;
	logic [KADDR_W-1:0]  cnt_q;      // prekey index i of next word
	logic [255:0]        win_q;      // last eight prekey words
	logic [127:0]        grp_q;      // four new prekey words
	logic [1:0]          sub_q;
	logic                wr_q;
	logic [RND_W-1:0]    wgrp_q;
	logic [1:0]          wsub_q;
	logic                rd_q;
	logic [1:0]          rsub_q;
	logic [1:0]          rcap_q;
	logic                rcv_q;
	logic [RND_W-1:0]    rgrp_q;
	logic [95:0]         acc_q;
	logic [31:0]         rdata;
	logic [255:0]        padded;
	logic [31:0]         nxt;
	logic [127:0]        sboxed;
	logic [2:0]          bsel;

	// Pad the key by its length.
	always_comb begin
		logic [5:0] l;
		l = (len_q > 6'd32) ? 6'd32 : len_q;
		for (int b = 0; b < 32; b++) begin
			if (6'(b) < l) begin
				padded[b*8 +: 8] = key_q[b*8 +: 8];
			end else if (6'(b) == l) begin
				padded[b*8 +: 8] = 8'h01;
			end else begin
				padded[b*8 +: 8] = 8'h00;
			end
		end
	end

	// One prekey word per cycle, held while a finished group goes to the writer.
	assign nxt = rotl(win_q[31:0] ^ win_q[127:96] ^ win_q[191:160] ^ win_q[255:224]
		^ GOLDEN ^ {24'd0, cnt_q}, 11);
	assign bsel = 3'(4'd11 - {1'b0, wgrp_q[2:0]});
	assign sboxed = sbox_slice(bsel, 1'b0, grp_q);

	// Key registers and expansion sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			len_q <= 6'd32;
			exp_q <= 1'b1;
			cnt_q <= '0;
			sub_q <= '0;
			wr_q <= 1'b0;
			wgrp_q <= '0;
			win_q <= '0;
		end else begin
			wr_q <= 1'b0;
			if (cfg_valid && cfg_index <= REG_KEYLEN) begin
				unique case (cfg_index)
					REG_KEY0:   key_q[63:0] <= cfg_data;
					REG_KEY1:   key_q[127:64] <= cfg_data;
					REG_KEY2:   key_q[191:128] <= cfg_data;
					REG_KEY3:   key_q[255:192] <= cfg_data;
					default:    len_q <= cfg_data[5:0];
				endcase
				exp_q <= 1'b1;
				cnt_q <= '0;
				sub_q <= '0;
				win_q <= '0;
			end else if (exp_q) begin
				if (cnt_q == '0 && sub_q == '0 && !wr_q && win_q == '0) begin
					win_q <= padded;
					sub_q <= 2'd1;
				end else if (wr_q) begin
					sub_q <= sub_q;
				end else begin
					win_q <= {nxt, win_q[255:32]};
					grp_q <= {nxt, grp_q[127:32]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[1:0] == 2'd3) begin
						wr_q <= 1'b1;
						wgrp_q <= RND_W'(cnt_q >> 2);
						if (cnt_q == KADDR_W'(KEY_WORDS - 1)) begin
							exp_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	// Write the four sboxed words, one a cycle, after the group completes.
	logic               wact_q;
	logic [127:0]       wbuf_q;
	logic [KADDR_W-1:0] waddr;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wact_q <= 1'b0;
			wsub_q <= '0;
		end else if (wr_q) begin
			wact_q <= 1'b1;
			wsub_q <= '0;
			wbuf_q <= sboxed;
		end else if (wact_q) begin
			wbuf_q <= {32'd0, wbuf_q[127:32]};
			wsub_q <= wsub_q + 1'b1;
			if (wsub_q == 2'd3) begin
				wact_q <= 1'b0;
			end
		end
	end
	assign waddr = KADDR_W'({wgrp_q, wsub_q});
	assign busy = exp_q | wr_q | wact_q;

	// Read four words for one subkey.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			rcv_q <= 1'b0;
			rsub_q <= '0;
			rcap_q <= '0;
			key_done <= 1'b0;
		end else begin
			key_done <= 1'b0;
			rcv_q <= rd_q;
			rcap_q <= rsub_q;
			if (fetch) begin
				rd_q <= 1'b1;
				rsub_q <= '0;
				rgrp_q <= fetch_grp;
			end else if (rd_q) begin
				rsub_q <= rsub_q + 1'b1;
				if (rsub_q == 2'd3) begin
					rd_q <= 1'b0;
				end
			end
			if (rcv_q) begin
				acc_q <= {rdata, acc_q[95:32]};
				if (rcap_q == 2'd3) begin
					subkey <= {rdata, acc_q};
					key_done <= 1'b1;
				end
			end
		end
	end

	spt_ram #(.WIDTH(32), .DEPTH(KEY_WORDS)) u_ram (
		.clk   (clk),
		.we    (wact_q),
		.waddr (waddr),
		.wdata (wbuf_q[31:0]),
		.raddr (KADDR_W'({rgrp_q, rsub_q})),
		.rdata (rdata)
	);

endmodule

/* rtl/spt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpent round datapath
// One shared round unit: key mix, S-box layer and linear transform.
// ----------------------------------------------------------------------------
module spt_datapath
	import spt_pkg::*;
(
	input  logic          clk,
	input  spt_cmd_t      cmd,
	input  logic [127:0]  block_in,
	input  logic [127:0]  subkey,
	input  logic [127:0]  last_key,
	output logic [127:0]  state
);

	logic [127:0] state_q;
	logic [127:0] nxt;

	// Forward round: mix, sbox, linear or final mix.
	// Inverse round: (linear inverse or final mix), inverse sbox, mix.
	always_comb begin
		logic [127:0] t;
		logic         last;
		last = (cmd.rnd == RND_W'(ROUND_COUNT - 1));
		if (!cmd.decrypt) begin
			t = sbox_slice(cmd.rnd[2:0], 1'b0, state_q ^ subkey);
			nxt = last ? (t ^ last_key) : lin_fwd(t);
		end else begin
			t = last ? (state_q ^ last_key) : lin_inv(state_q);
			nxt = sbox_slice(cmd.rnd[2:0], 1'b1, t) ^ subkey;
		end
	end

	// Block register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= block_in;
		end else if (cmd.round) begin
			state_q <= nxt;
		end
	end

	assign state = state_q;

endmodule

/* rtl/spt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpent controller
// Sequences subkey fetches and round steps for one block at a time.
// ----------------------------------------------------------------------------
module spt_ctrl
	import spt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_cmd,
	output logic       in_ready,
	input  logic       ks_busy,
	input  logic       key_done,
	input  logic       out_free,
	output logic       out_load,
	output logic       last_cap,
	output spt_cmd_t   cmd,
	output logic       fetch,
	output logic [RND_W-1:0] fetch_grp
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LAST  = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t           st_q;
	logic             dec_q;
	logic [RND_W-1:0] rnd_q;
	logic [RND_W-1:0] cnt_q;

	assign in_ready = (st_q == ST_IDLE) && !ks_busy;

	// Round sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			dec_q <= 1'b0;
			rnd_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						dec_q <= in_cmd;
						rnd_q <= in_cmd ? RND_W'(ROUND_COUNT - 1) : '0;
						cnt_q <= '0;
						st_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (key_done) begin
						st_q <= ST_FETCH;
					end
				end
				ST_FETCH: st_q <= ST_WAIT;
				ST_WAIT: begin
					if (key_done) begin
						cnt_q <= cnt_q + 1'b1;
						rnd_q <= dec_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
						st_q <= (cnt_q == RND_W'(ROUND_COUNT - 1)) ? ST_OUT : ST_FETCH;
					end
				end
				default: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign fetch = (st_q == ST_IDLE && in_valid && in_ready) || (st_q == ST_FETCH);
	assign fetch_grp = (st_q == ST_IDLE) ? RND_W'(ROUND_COUNT) : rnd_q;
	assign last_cap = (st_q == ST_LAST) && key_done;
	assign out_load = (st_q == ST_OUT) && out_free;

	always_comb begin
		cmd.load = (st_q == ST_IDLE) && in_valid && in_ready;
		cmd.round = (st_q == ST_WAIT) && key_done;
		cmd.decrypt = dec_q;
		cmd.rnd = rnd_q;
	end

endmodule
